FILE: design/bpa_pkg.sv
// Package for the buddy page allocator: geometry constants, shared types and helpers.
// Used by bpa_ctrl, bpa_datapath and buddy_page_allocator_top.
package bpa_pkg;

  localparam int NumOrders   = 4;
  localparam int MinPageBits = 8;
  localparam int TopPages    = 16;
  localparam int MaxBits     = TopPages << (NumOrders - 1);
  localparam int IdxW        = $clog2(MaxBits);
  localparam int OrdW        = 2;

  typedef logic [OrdW-1:0] ord_t;
  typedef logic [IdxW-1:0] idx_t;

  // commands from controller to datapath
  typedef enum logic [2:0] {
    CmdNone,
    CmdLoad,
    CmdSplit,
    CmdTake,
    CmdMerge,
    CmdMark,
    CmdFail
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    ord_t lvl;
  } ctrl_t;

  typedef struct packed {
    logic [NumOrders-1:0] has_free;
    logic                 buddy_free;
  } stat_t;

  function automatic int unsigned pages_at(input int unsigned o);
    return TopPages << (NumOrders - 1 - o);
  endfunction

endpackage

FILE: design/bpa_datapath.sv
// Datapath: free bitmaps per order, request registers, result registers.
// Depends on bpa_pkg; driven by bpa_ctrl commands.
module bpa_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [31:0]      pool_base_i,
  input  bpa_pkg::ord_t    order_i,
  input  logic [31:0]      address_i,
  input  bpa_pkg::ctrl_t   ctrl_i,
  output bpa_pkg::stat_t   stat_o,
  output logic             ok_o,
  output logic [31:0]      page_address_o
);

  logic [bpa_pkg::MaxBits-1:0] map_q [bpa_pkg::NumOrders];
  logic [31:0] off_q;
  bpa_pkg::ord_t ord_q;
  logic [31:0] res_addr_q;
  logic        res_ok_q;
  bpa_pkg::idx_t ff_idx;
  bpa_pkg::idx_t cur_idx;
  logic [31:0] sh_off;

  // first free index at the selected order
  always_comb begin
    ff_idx = '0;
    for (int i = bpa_pkg::MaxBits - 1; i >= 0; i--) begin
      if (map_q[ctrl_i.lvl][i]) ff_idx = bpa_pkg::IdxW'(i);
    end
  end

  // index of the freed page at the selected order
  always_comb begin
    sh_off  = off_q >> (32'(ctrl_i.lvl) + 32'(bpa_pkg::MinPageBits));
    cur_idx = sh_off[bpa_pkg::IdxW-1:0];
  end

  // status toward the controller
  always_comb begin
    for (int o = 0; o < bpa_pkg::NumOrders; o++) begin
      stat_o.has_free[o] = |map_q[o];
    end
    stat_o.buddy_free = (sh_off < 32'(bpa_pkg::pages_at(32'(ctrl_i.lvl)))) &&
                        map_q[ctrl_i.lvl][cur_idx ^ bpa_pkg::IdxW'(1)];
  end

  // bitmap update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int o = 0; o < bpa_pkg::NumOrders; o++) map_q[o] <= '0;
      map_q[bpa_pkg::NumOrders-1][bpa_pkg::TopPages-2:0] <= '1;
    end else begin
      case (ctrl_i.cmd)
        bpa_pkg::CmdSplit: begin
          map_q[ctrl_i.lvl][ff_idx] <= 1'b0;
          map_q[ctrl_i.lvl - 1'b1][{ff_idx[bpa_pkg::IdxW-2:0], 1'b0}] <= 1'b1;
          map_q[ctrl_i.lvl - 1'b1][{ff_idx[bpa_pkg::IdxW-2:0], 1'b1}] <= 1'b1;
        end
        bpa_pkg::CmdTake: map_q[ctrl_i.lvl][ff_idx] <= 1'b0;
        bpa_pkg::CmdMerge: map_q[ctrl_i.lvl][cur_idx ^ bpa_pkg::IdxW'(1)] <= 1'b0;
        bpa_pkg::CmdMark: begin
          if (sh_off < 32'(bpa_pkg::pages_at(32'(ctrl_i.lvl))))
            map_q[ctrl_i.lvl][cur_idx] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // request and result registers
  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      bpa_pkg::CmdLoad: begin
        off_q      <= address_i - pool_base_i;
        ord_q      <= order_i;
        res_ok_q   <= 1'b1;
        res_addr_q <= '0;
      end
      bpa_pkg::CmdTake: begin
        res_addr_q <= pool_base_i +
          (32'(ff_idx) << (32'(ord_q) + 32'(bpa_pkg::MinPageBits)));
      end
      bpa_pkg::CmdMerge: begin
        off_q <= off_q & ~((32'd1 << (32'(ctrl_i.lvl) + 32'(bpa_pkg::MinPageBits) + 32'd1))
                 - 32'd1);
      end
      bpa_pkg::CmdFail: begin
        res_ok_q   <= 1'b0;
        res_addr_q <= '0;
      end
      default: ;
    endcase
  end

  assign ok_o           = res_ok_q;
  assign page_address_o = res_addr_q;

endmodule

FILE: design/bpa_ctrl.sv
// Controller: sequences allocate search/split and free coalesce steps.
// Depends on bpa_pkg; drives bpa_datapath.
module bpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           action_i,
  input  bpa_pkg::ord_t  order_i,
  input  bpa_pkg::stat_t stat_i,
  output bpa_pkg::ctrl_t ctrl_o,
  output logic           busy,
  output logic           done_o
);

  typedef enum logic [2:0] {SIdle, SSearch, SSplit, SFree, SDone} state_e;

  state_e        state_q;
  bpa_pkg::ord_t lvl_q, req_q;
  logic          done_q;

  // command decode
  always_comb begin
    ctrl_o.cmd = bpa_pkg::CmdNone;
    ctrl_o.lvl = lvl_q;
    unique case (state_q)
      SIdle: if (start && !done_q) ctrl_o.cmd = bpa_pkg::CmdLoad;
      SSearch: if (!(|(stat_i.has_free >> req_q))) ctrl_o.cmd = bpa_pkg::CmdFail;
      SSplit: ctrl_o.cmd = (lvl_q == req_q) ? bpa_pkg::CmdTake : bpa_pkg::CmdSplit;
      SFree: begin
        if (lvl_q != bpa_pkg::ord_t'(bpa_pkg::NumOrders - 1) && stat_i.buddy_free)
          ctrl_o.cmd = bpa_pkg::CmdMerge;
        else
          ctrl_o.cmd = bpa_pkg::CmdMark;
      end
      default: ;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      lvl_q   <= '0;
      req_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        SIdle: if (start && !done_q) begin
          state_q <= action_i ? SFree : SSearch;
          req_q   <= order_i;
          lvl_q   <= order_i;
        end
        SSearch: begin
          if (!(|(stat_i.has_free >> req_q))) state_q <= SDone;
          else if (stat_i.has_free[lvl_q]) state_q <= SSplit;
          else lvl_q <= lvl_q + 1'b1;
        end
        SSplit: begin
          if (lvl_q == req_q) state_q <= SDone;
          else lvl_q <= lvl_q - 1'b1;
        end
        SFree: begin
          if (ctrl_o.cmd == bpa_pkg::CmdMerge) lvl_q <= lvl_q + 1'b1;
          else state_q <= SDone;
        end
        SDone: begin
          done_q  <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign busy   = (state_q != SIdle) || done_q;
  assign done_o = done_q;

  // a result pulse is never back to back
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done repeated");
  // split only above the requested order
  a_split_lvl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.cmd == bpa_pkg::CmdSplit) |-> (lvl_q > req_q)) else $error("bad split");
  // merge never at top order
  a_merge_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.cmd == bpa_pkg::CmdMerge) |->
      (lvl_q != bpa_pkg::ord_t'(bpa_pkg::NumOrders - 1))) else $error("top merge");

endmodule

FILE: design/buddy_page_allocator_top.sv
// Top level of the buddy page allocator: config register, controller, datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
//
// Usage: raise start with action_i, order_i and address_i while busy is low; the
// beat is taken at that edge. One result beat follows, shown for one cycle with
// done_o high on ok_o and page_address_o.
// An allocate searches up from order_i for a free page, splits it down to order_i and
// takes one half; a failed allocate ends after the search. A free merges with free
// buddies order by order, then marks the page free. The controller walks the orders
// one order per cycle. One request in flight at a time; busy stays high through the
// result beat, so the next beat is taken only after it.
// Config: cfg_valid_i/cfg_ready_o writes pool_base, taken whenever both are high;
// write only while idle.
// Reset: pool_base 0, order 3 pages 0..14 free, lower orders empty.
// The receiver cannot stall; results must be taken on the strobe.
module buddy_page_allocator_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic          action_i,
  input  logic [1:0]    order_i,
  input  logic [31:0]   address_i,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [31:0]   cfg_data_i,
  output logic          done_o,
  output logic          ok_o,
  output logic [31:0]   page_address_o
);

  logic [31:0]    pool_base_q;
  bpa_pkg::ctrl_t ctrl;
  bpa_pkg::stat_t stat;

  // hold the pool base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pool_base_q <= '0;
    else if (cfg_valid_i) pool_base_q <= cfg_data_i;
  end
  assign cfg_ready_o = 1'b1;

  bpa_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .action_i, .order_i,
    .stat_i(stat), .ctrl_o(ctrl), .busy, .done_o
  );

  bpa_datapath u_dp (
    .clk_i, .rst_ni, .pool_base_i(pool_base_q), .order_i, .address_i,
    .ctrl_i(ctrl), .stat_o(stat), .ok_o, .page_address_o
  );

endmodule

FILE: sim/tb.sv
// Testbench for buddy_page_allocator_top: allocate and free traffic is checked beat by beat
// against a bitmap model of the buddy free maps held in the testbench.
// Depends on bpa_pkg and the design files under design/.
`timescale 1ns / 100ps

module tb;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 20;
  localparam logic ActAlloc    = 1'b0;
  localparam logic ActFree     = 1'b1;

  typedef struct {
    logic        ok;
    logic [31:0] page_addr;
  } alloc_result_t;

  typedef struct {
    logic [31:0]   addr;
    bpa_pkg::ord_t ord;
  } live_page_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        action_i = 1'b0;
  logic [1:0]  order_i = '0;
  logic [31:0] address_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        busy;
  logic        cfg_ready_o;
  logic        done_o;
  logic        ok_o;
  logic [31:0] page_address_o;

  // model state
  logic [bpa_pkg::MaxBits-1:0] free_map [bpa_pkg::NumOrders];
  logic [31:0]        model_base;
  alloc_result_t      pending_results [$];
  live_page_t         live_pages [$];
  int                 mismatches = 0;
  int                 idle_cycles = 0;
  bit                 idle_en = 1'b1;

  buddy_page_allocator_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .order_i        (order_i),
    .address_i      (address_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .ok_o           (ok_o),
    .page_address_o (page_address_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned map_pages(input int unsigned o);
    return bpa_pkg::TopPages << (bpa_pkg::NumOrders - 1 - o);
  endfunction

  function automatic bit map_get(input int unsigned o, input logic [31:0] i);
    return (i < map_pages(o)) && free_map[o][i];
  endfunction

  function automatic void map_put(input int unsigned o, input logic [31:0] i, input logic v);
    if (i < map_pages(o)) free_map[o][i] = v;
  endfunction

  function automatic int unsigned lowest_free(input int unsigned o);
    for (int unsigned i = 0; i < map_pages(o); i++) begin
      if (free_map[o][i]) return i;
    end
    return map_pages(o);
  endfunction

  function automatic void reset_free_maps();
    model_base = '0;
    for (int o = 0; o < bpa_pkg::NumOrders; o++) free_map[o] = '0;
    for (int i = 0; i + 1 < bpa_pkg::TopPages; i++)
      free_map[bpa_pkg::NumOrders-1][i] = 1'b1;
  endfunction

  // Work out the answer to one request and update the free maps.
  function automatic alloc_result_t buddy_predict(input logic act, input bpa_pkg::ord_t ord,
                                                  input logic [31:0] addr);
    alloc_result_t r;
    int unsigned   o;
    int unsigned   idx;
    logic [31:0]   off;
    logic [31:0]   pidx;
    r.ok = 1'b1;
    r.page_addr = '0;
    if (act == ActAlloc) begin
      o = ord;
      while (o < bpa_pkg::NumOrders && lowest_free(o) >= map_pages(o)) o++;
      if (o >= bpa_pkg::NumOrders) begin
        r.ok = 1'b0;
        return r;
      end
      for (; o > ord; o--) begin
        idx = lowest_free(o);
        map_put(o, idx, 1'b0);
        map_put(o - 1, idx * 2, 1'b1);
        map_put(o - 1, idx * 2 + 1, 1'b1);
      end
      idx = lowest_free(ord);
      map_put(ord, idx, 1'b0);
      r.page_addr = model_base + (32'(idx) << (int'(ord) + bpa_pkg::MinPageBits));
    end else begin
      off = addr - model_base;
      for (o = ord; o < bpa_pkg::NumOrders - 1; o++) begin
        pidx = off >> (o + bpa_pkg::MinPageBits);
        if (pidx < map_pages(o) && map_get(o, pidx ^ 32'd1)) begin
          map_put(o, pidx ^ 32'd1, 1'b0);
          off &= ~((32'd1 << (o + 1 + bpa_pkg::MinPageBits)) - 32'd1);
        end else begin
          map_put(o, pidx, 1'b1);
          return r;
        end
      end
      map_put(o, off >> (o + bpa_pkg::MinPageBits), 1'b1);
    end
    return r;
  endfunction

  // Send one request beat; hold start high so back-to-back beats need no second write.
  task automatic send_request(input logic act, input bpa_pkg::ord_t ord,
                              input logic [31:0] addr);
    alloc_result_t r;
    live_page_t    lp;
    int            gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    action_i  <= act;
    order_i   <= ord;
    address_i <= addr;
    do @(posedge clk_i); while (busy);
    r = buddy_predict(act, ord, addr);
    pending_results.push_back(r);
    if (act == ActAlloc && r.ok) begin
      lp.addr = r.page_addr;
      lp.ord  = ord;
      live_pages.push_back(lp);
    end
  endtask

  task automatic stop_and_drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic free_live_pages();
    live_page_t lp;
    while (live_pages.size() != 0) begin
      lp = live_pages.pop_front();
      send_request(ActFree, lp.ord, lp.addr);
    end
  endtask

  // Write pool_base while the block is idle.
  task automatic write_pool_base(input logic [31:0] base);
    stop_and_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    model_base = base;
    @(posedge clk_i);
  endtask

  // Split every order, free back with merges, free outside the pool, exhaust top order.
  task automatic test_split_and_merge();
    live_page_t lp;
    for (int o = 0; o < bpa_pkg::NumOrders; o++)
      send_request(ActAlloc, bpa_pkg::ord_t'(o), $urandom());
    while (live_pages.size() != 0) begin
      lp = live_pages.pop_back();
      send_request(ActFree, lp.ord, lp.addr);
    end
    send_request(ActFree, bpa_pkg::ord_t'(0), 32'hFFFF_FFFF);
    send_request(ActFree, bpa_pkg::ord_t'(3), model_base + 32'h0000_8000);
    for (int i = 0; i < bpa_pkg::TopPages; i++)
      send_request(ActAlloc, bpa_pkg::ord_t'(bpa_pkg::NumOrders - 1), '0);
    send_request(ActAlloc, bpa_pkg::ord_t'(0), '0);
    free_live_pages();
  endtask

  // Mostly alloc/free pairs of real pages, with some stray frees as noise.
  task automatic test_random_traffic(input int n_items);
    live_page_t lp;
    int         pick;
    int         sel;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 || live_pages.size() == 0) begin
        sel = $urandom_range(0, 9);
        send_request(ActAlloc,
                     bpa_pkg::ord_t'(sel < 4 ? 0 : sel < 7 ? 1 : sel < 9 ? 2 : 3),
                     $urandom());
      end else if (pick < 93) begin
        sel = $urandom_range(0, live_pages.size() - 1);
        lp = live_pages[sel];
        live_pages.delete(sel);
        send_request(ActFree, lp.ord, lp.addr);
      end else if (pick < 96) begin
        send_request(ActFree, bpa_pkg::ord_t'($urandom_range(0, 3)), $urandom());
      end else begin
        send_request(ActFree, bpa_pkg::ord_t'($urandom_range(0, 3)),
                     model_base + ($urandom() & 32'h0000_7F00));
      end
    end
    free_live_pages();
  endtask

  // Check each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    alloc_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: ok %0b addr %h", ok_o, page_address_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (ok_o !== exp_r.ok || page_address_o !== exp_r.page_addr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected ok %0b addr %h, got ok %0b addr %h",
                     exp_r.ok, exp_r.page_addr, ok_o, page_address_o);
        end
      end
    end
  end

  // Count cycles with no beat moving on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    reset_free_maps();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_pool_base(32'h0000_0000);
    test_split_and_merge();
    test_random_traffic(380);
    write_pool_base(32'hFFFF_F800);
    test_split_and_merge();
    test_random_traffic(330);
    write_pool_base(32'h0000_07FF);
    test_random_traffic(300);
    write_pool_base($urandom() & 32'hFFFF_F800);
    test_random_traffic(300);
    write_pool_base(32'h0000_0000);
    idle_en = 1'b0;
    test_random_traffic(300);

    stop_and_drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/bpa_pkg.sv
design/bpa_datapath.sv
design/bpa_ctrl.sv
design/buddy_page_allocator_top.sv
sim/tb.sv
